// ===== rtl/sbpd_pkg.sv =====
// shared constants for the seven-bit packet deframer
package sbpd_pkg;

   localparam int TABLE_SLOTS          = 4;
   localparam int NUM_PACKET_TYPES_DEF = 4;
   localparam int MAX_PACKET_LEN_DEF   = 10;

   localparam int ID_W       = 7;
   localparam int LEN_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int OUT_IDX_W  = 4;
   localparam int SLOT_W     = 2;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 7;

   // register map: even index is an id, odd index is a length
   localparam int         CSR_REG_COUNT = 2 * TABLE_SLOTS;
   localparam logic       CSR_SEL_ID    = 1'b0;
   localparam logic       CSR_SEL_LEN   = 1'b1;

   localparam logic [LEN_W-1:0] MIN_USED_LEN = 4'd2;

endpackage

// ===== rtl/seven_bit_packet_deframer_top.sv =====
// seven-bit packet deframer: id lookup, byte collection and restored-byte readout
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  rx_byte
//   rsp_     out  rsp_valid/rsp_stall  packet_id, byte_index, byte_value, last_byte
//   csr_     in   csr_valid/csr_ready  csr_index, csr_wdata
//
// a data byte is taken in the idle state; an id byte starts a table lookup
// by the single id/length comparator that walks the table one entry a cycle
// the byte that completes a packet starts the readout: one restored byte per cycle,
// while the output register is free, through the readout mux and bit-restore logic
// req_stall is high whenever the sequencer is busy with lookup or readout
// rsp_stall holds the output register; readout waits until the register frees
// reset is synchronous, active high; it clears the table and all control state
module seven_bit_packet_deframer_top
   import sbpd_pkg::*;
#(
   parameter int NUM_PACKET_TYPES = NUM_PACKET_TYPES_DEF,
   parameter int MAX_PACKET_LEN   = MAX_PACKET_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ID_W-1:0]       rsp_packet_id,
   output logic [OUT_IDX_W-1:0]  rsp_byte_index,
   output logic [BYTE_W-1:0]     rsp_byte_value,
   output logic                  rsp_last_byte,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_PACKET_LEN);
   localparam int CNT_W = $clog2(MAX_PACKET_LEN + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   // configuration table
   logic [ID_W-1:0]  cfg_id_ff  [TABLE_SLOTS];
   logic [LEN_W-1:0] cfg_len_ff [TABLE_SLOTS];

   // packet buffer, written one byte per request
   logic [BYTE_W-1:0] buf_ff [MAX_PACKET_LEN];

   state_type         state_ff,     state_in;
   logic [SLOT_W-1:0] scan_k_ff,    scan_k_in;
   logic [ID_W-1:0]   id_ff,        id_in;
   logic [LEN_W-1:0]  found_len_ff, found_len_in;
   logic [CNT_W-1:0]  cnt_ff,       cnt_in;
   logic              active_ff,    active_in;
   logic [LEN_W-1:0]  exp_len_ff,   exp_len_in;
   logic [IDX_W-1:0]  emit_idx_ff,  emit_idx_in;

   logic                 rsp_valid_ff,     rsp_valid_in;
   logic [ID_W-1:0]      rsp_packet_id_ff, rsp_packet_id_in;
   logic [OUT_IDX_W-1:0] rsp_index_ff,     rsp_index_in;
   logic [BYTE_W-1:0]    rsp_value_ff,     rsp_value_in;
   logic                 rsp_last_ff,      rsp_last_in;

   // buffer write port
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [BYTE_W-1:0] wr_data;

   // shared comparator and readout
   logic [LEN_W-1:0]  scan_len;
   logic              entry_hit;
   logic [LEN_W-1:0]  hit_len;
   logic              req_fire;
   logic              rsp_free;
   logic [LEN_W-1:0]  cnt_wide;
   logic [LEN_W-1:0]  emit_wide;
   logic [LEN_W-1:0]  shift_amt;
   logic [BYTE_W-1:0] rd_byte;
   logic [BYTE_W-1:0] byte_one;
   logic              emit_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_packet_id  = rsp_packet_id_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_byte_value = rsp_value_ff;
   assign rsp_last_byte  = rsp_last_ff;

   // one table entry per lookup cycle; a later hit overrides an earlier one
   assign scan_len  = cfg_len_ff[scan_k_ff];
   assign entry_hit = (scan_len >= MIN_USED_LEN)
                    && (scan_len <= LEN_W'(MAX_PACKET_LEN))
                    && (cfg_id_ff[scan_k_ff] == id_ff);
   assign hit_len   = entry_hit ? scan_len : found_len_ff;

   assign cnt_wide  = LEN_W'(cnt_ff);
   assign emit_wide = LEN_W'(emit_idx_ff);
   assign shift_amt = emit_wide - MIN_USED_LEN;
   assign rd_byte   = buf_ff[emit_idx_ff];
   assign byte_one  = buf_ff[1];
   assign emit_last = ((emit_wide + 4'd1) == exp_len_ff);

   always_comb begin
      state_in         = state_ff;
      scan_k_in        = scan_k_ff;
      id_in            = id_ff;
      found_len_in     = found_len_ff;
      cnt_in           = cnt_ff;
      active_in        = active_ff;
      exp_len_in       = exp_len_ff;
      emit_idx_in      = emit_idx_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_packet_id_in = rsp_packet_id_ff;
      rsp_index_in     = rsp_index_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_last_in      = rsp_last_ff;
      wr_en            = 1'b0;
      wr_addr          = '0;
      wr_data          = req_rx_byte;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_rx_byte[BYTE_W-1]) begin
                  // id byte: start the table walk
                  id_in        = req_rx_byte[ID_W-1:0];
                  scan_k_in    = '0;
                  found_len_in = '0;
                  state_in     = ST_LOOKUP;
               end else if (active_ff) begin
                  if ((cnt_wide >= LEN_W'(MAX_PACKET_LEN)) || (cnt_wide >= exp_len_ff)) begin
                     cnt_in    = '0;
                     active_in = 1'b0;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = cnt_ff[IDX_W-1:0];
                     cnt_in  = cnt_ff + CNT_W'(1);
                     if ((cnt_wide + 4'd1) == exp_len_ff) begin
                        // packet complete: read it out
                        cnt_in      = '0;
                        active_in   = 1'b0;
                        emit_idx_in = '0;
                        state_in    = ST_EMIT;
                     end
                  end
               end
            end
         end

         ST_LOOKUP: begin
            found_len_in = hit_len;
            scan_k_in    = scan_k_ff + SLOT_W'(1);
            if (scan_k_ff == SLOT_W'(NUM_PACKET_TYPES - 1)) begin
               state_in = ST_IDLE;
               if (hit_len != '0) begin
                  wr_en      = 1'b1;
                  wr_addr    = '0;
                  wr_data    = {1'b0, id_ff};
                  cnt_in     = CNT_W'(1);
                  active_in  = 1'b1;
                  exp_len_in = hit_len;
               end else begin
                  cnt_in     = '0;
                  active_in  = 1'b0;
                  exp_len_in = '0;
               end
            end
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_packet_id_in = buf_ff[0][ID_W-1:0];
               rsp_index_in     = emit_wide;
               rsp_last_in      = emit_last;
               // bytes two and up take their top bit from byte one
               if (emit_wide >= MIN_USED_LEN) begin
                  rsp_value_in = {byte_one[shift_amt[2:0]], rd_byte[BYTE_W-2:0]};
               end else begin
                  rsp_value_in = rd_byte;
               end
               emit_idx_in = emit_idx_ff + IDX_W'(1);
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_k_ff    <= '0;
         found_len_ff <= '0;
         cnt_ff       <= '0;
         active_ff    <= 1'b0;
         exp_len_ff   <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_k_ff    <= scan_k_in;
         found_len_ff <= found_len_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         exp_len_ff   <= exp_len_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff            <= id_in;
      rsp_packet_id_ff <= rsp_packet_id_in;
      rsp_index_ff     <= rsp_index_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_last_ff      <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_ff[wr_addr] <= wr_data;
      end
   end

   // register writes; indexes past the table are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TABLE_SLOTS; k++) begin
            cfg_id_ff[k]  <= '0;
            cfg_len_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready
                   && (csr_index < CSR_IDX_W'(CSR_REG_COUNT))) begin
         if (csr_index[0] == CSR_SEL_ID) begin
            cfg_id_ff[csr_index[SLOT_W:1]] <= csr_wdata[ID_W-1:0];
         end else begin
            cfg_len_ff[csr_index[SLOT_W:1]] <= csr_wdata[LEN_W-1:0];
         end
      end
   end

`ifndef SYNTHESIS
   // an open packet never holds as many bytes as its length
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cnt_wide < exp_len_ff))
      else $error("byte count reached length while packet open");

   // byte zero is the id, byte one is a raw data byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_byte_index == 4'd0)) |-> !rsp_byte_value[BYTE_W-1])
      else $error("byte zero carries a top bit");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_byte_index == 4'd1)) |-> rsp_byte_value[BYTE_W-1])
      else $error("byte one lost its top bit");

   // a packet has at least two bytes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte) |-> (rsp_byte_index != 4'd0))
      else $error("last flag on byte zero");
`endif

endmodule
